// ===== hdl/pfms_pkg.sv =====
// ----------------------------------------------------------------------------
// pfms_pkg
// Shared types, constants and helpers for the permuted cardinality sketch.
// ----------------------------------------------------------------------------
package pfms_pkg;

    localparam int NUM_ROWS_DEF    = 256;
    localparam int NUM_NIBBLES_DEF = 8;
    localparam int HASH_W          = 32;
    localparam int ORDER_W         = 24;
    localparam int IDX_W           = 8;
    localparam int POS_W           = 3;
    localparam int RUN_W           = 6;   // leading-ones count, 0..32
    localparam int SUM_W           = 64;

    // request kinds
    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_OFFER = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OFFER,
        ST_QUERY,
        ST_DIV,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch request fields
        logic load_row;    // write order table
        logic walk_clr;    // reset row pointer
        logic walk_step;   // advance row pointer
        logic offer_en;    // rows being updated
        logic query_en;    // rows being summed
        logic div_start;   // begin divide
        logic div_step;    // one quotient bit
        logic emit;        // drive result
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic walk_last;   // last row issued
        logic pipe_empty;  // read pipeline drained
        logic div_last;    // final quotient bit
    } stat_t;

    // leading ones of a 32-bit word, saturating at 32
    function automatic logic [RUN_W-1:0] lead_ones(input logic [HASH_W-1:0] v);
        logic [RUN_W-1:0] n;
        logic             run;
        n   = '0;
        run = 1'b1;
        for (int i = HASH_W - 1; i >= 0; i--) begin
            if (run && v[i])
                n = n + 1'b1;
            else
                run = 1'b0;
        end
        return n;
    endfunction

endpackage

// ===== hdl/pfms_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfms_ctrl
// Sequencer: row walks for offers and queries, then the bit-serial divide.
// ----------------------------------------------------------------------------
module pfms_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        kind,
    input  pfms_pkg::stat_t   stat,
    output pfms_pkg::ctrl_t   ctrl,
    output logic              busy
);

    pfms_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pfms_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfms_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == pfms_pkg::KIND_OFFER)
                        state_next = pfms_pkg::ST_OFFER;
                    else if (kind == pfms_pkg::KIND_QUERY)
                        state_next = pfms_pkg::ST_QUERY;
                end
            end
            pfms_pkg::ST_OFFER:
                if (stat.walk_last) state_next = pfms_pkg::ST_DONE;
            pfms_pkg::ST_QUERY:
                if (stat.walk_last) state_next = pfms_pkg::ST_DIV;
            pfms_pkg::ST_DIV:
                if (stat.pipe_empty && stat.div_last) state_next = pfms_pkg::ST_DONE;
            pfms_pkg::ST_DONE:
                if (stat.pipe_empty) state_next = pfms_pkg::ST_IDLE;
            default:
                state_next = pfms_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl = '0;
        busy = (state_reg != pfms_pkg::ST_IDLE);
        case (state_reg)
            pfms_pkg::ST_IDLE:
            begin
                ctrl.capture  = start;
                ctrl.load_row = start && (kind == pfms_pkg::KIND_LOAD);
                ctrl.walk_clr = 1'b1;
            end
            pfms_pkg::ST_OFFER:
            begin
                ctrl.offer_en  = 1'b1;
                ctrl.walk_step = 1'b1;
            end
            pfms_pkg::ST_QUERY:
            begin
                ctrl.query_en  = 1'b1;
                ctrl.walk_step = 1'b1;
            end
            pfms_pkg::ST_DIV:
            begin
                // wait for the sum pipeline to drain before dividing
                ctrl.div_start = stat.pipe_empty && !stat.div_last;
                ctrl.div_step  = stat.pipe_empty;
                ctrl.emit      = stat.pipe_empty && stat.div_last;
            end
            pfms_pkg::ST_DONE: ;
            default: ;
        endcase
    end

endmodule

// ===== hdl/pfms_dp.sv =====
// ----------------------------------------------------------------------------
// pfms_dp
// Datapath: order table, bitmap memory, per-row offset unit, term
// accumulator and a restoring divider.
// ----------------------------------------------------------------------------
module pfms_dp
#(
    parameter int NUM_ROWS    = pfms_pkg::NUM_ROWS_DEF,
    parameter int NUM_NIBBLES = pfms_pkg::NUM_NIBBLES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfms_pkg::ctrl_t               ctrl,
    input  logic [pfms_pkg::HASH_W-1:0]   hash_value,
    input  logic [pfms_pkg::IDX_W-1:0]    row_index,
    input  logic [pfms_pkg::ORDER_W-1:0]  row_order,
    output pfms_pkg::stat_t               stat,
    output logic                          result_valid,
    output logic [pfms_pkg::HASH_W-1:0]   estimate
);

    localparam int RW      = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int SUB_W   = pfms_pkg::HASH_W / NUM_NIBBLES;
    localparam int NPOS    = pfms_pkg::ORDER_W / pfms_pkg::POS_W;
    localparam int OFF_W   = 7;
    localparam int Q_W     = 64;
    localparam int DIV_N   = Q_W;
    localparam int DC_W    = $clog2(DIV_N);

    // order table and bitmaps
    logic [pfms_pkg::ORDER_W-1:0] order_mem [NUM_ROWS];
    logic [pfms_pkg::HASH_W-1:0]  bmp_mem   [NUM_ROWS];
    logic [NUM_ROWS-1:0]          bmp_vld_reg;

    logic [pfms_pkg::HASH_W-1:0]  hash_reg;
    logic [RW:0]                  ptr_reg;

    // pipeline: stage 1 = memory read, stage 2 = update/accumulate
    logic                         s1_vld_reg, s1_off_reg, s1_qry_reg;
    logic [RW-1:0]                s1_row_reg;
    logic [pfms_pkg::ORDER_W-1:0] s1_ord_reg;
    logic [pfms_pkg::HASH_W-1:0]  s1_bmp_raw_reg;

    logic [pfms_pkg::SUM_W-1:0]   sum_reg;
    logic [Q_W-1:0]               num_reg;
    logic [Q_W:0]                 rem_reg;
    logic [Q_W-1:0]               quo_reg;
    logic [DC_W:0]                dcnt_reg;
    logic                         div_busy_reg;

    logic [pfms_pkg::HASH_W-1:0]  s1_bmp;
    logic [OFF_W-1:0]             offset;
    logic                         offset_hit;

    logic                         walk_last;
    logic                         pipe_empty;
    logic                         div_last;

    // status to the controller
    assign stat = {walk_last, pipe_empty, div_last};

    // request capture and row pointer
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
            hash_reg <= hash_value;
        if (ctrl.load_row && ({{(32-pfms_pkg::IDX_W){1'b0}}, row_index} < 32'(NUM_ROWS)))
            order_mem[row_index[RW-1:0]] <= row_order;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptr_reg <= '0;
        else if (ctrl.walk_clr)
            ptr_reg <= '0;
        else if (ctrl.walk_step)
            ptr_reg <= ptr_reg + 1'b1;
    end

    assign walk_last = (ptr_reg == (RW + 1)'(NUM_ROWS - 1));

    // stage 1: registered memory reads
    always_ff @(posedge clk)
    begin
        s1_ord_reg     <= order_mem[ptr_reg[RW-1:0]];
        s1_bmp_raw_reg <= bmp_mem[ptr_reg[RW-1:0]];
        s1_row_reg     <= ptr_reg[RW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s1_off_reg <= 1'b0;
            s1_qry_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= ctrl.walk_step;
            s1_off_reg <= ctrl.offer_en;
            s1_qry_reg <= ctrl.query_en;
        end
    end

    assign pipe_empty = !s1_vld_reg;

    // a bitmap never written since reset reads as zero
    assign s1_bmp = bmp_vld_reg[s1_row_reg] ? s1_bmp_raw_reg : '0;

    // offset: leading zeros of the hash with sub-words in row order
    always_comb
    begin
        logic [pfms_pkg::POS_W-1:0] k;
        logic [SUB_W-1:0]           s;
        logic                       found;
        offset     = '0;
        found      = 1'b0;
        for (int j = 0; j < NUM_NIBBLES; j++) begin
            if (j < NPOS)
                k = s1_ord_reg[pfms_pkg::POS_W*(j % NPOS) +: pfms_pkg::POS_W];
            else
                k = '0;
            s = (int'(k) < NUM_NIBBLES) ? hash_reg[SUB_W*int'(k) +: SUB_W] : '0;
            if (!found)
            begin
                if (s == '0)
                    offset = offset + OFF_W'(SUB_W);
                else
                begin
                    for (int b = SUB_W - 1; b >= 0; b--) begin
                        if (!found)
                        begin
                            if (s[b])
                                found = 1'b1;
                            else
                                offset = offset + 1'b1;
                        end
                    end
                end
            end
        end
        offset_hit = (offset <= OFF_W'(31));
    end

    // stage 2: bitmap write-back
    always_ff @(posedge clk)
    begin
        if (s1_vld_reg && s1_off_reg && offset_hit)
            bmp_mem[s1_row_reg] <= s1_bmp | (32'h8000_0000 >> offset[4:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bmp_vld_reg <= '0;
        else if (s1_vld_reg && s1_off_reg && offset_hit)
            bmp_vld_reg[s1_row_reg] <= 1'b1;
    end

    // term accumulation: 2^(32-R) per row
    always_ff @(posedge clk)
    begin
        if (ctrl.walk_clr)
            sum_reg <= '0;
        else if (s1_vld_reg && s1_qry_reg)
            sum_reg <= sum_reg + (64'd1 << (7'd32 - {1'b0, pfms_pkg::lead_ones(s1_bmp)}));
    end

    // restoring divide: NUM_ROWS * 2^32 / sum, one quotient bit a cycle while div_step is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            dcnt_reg     <= '0;
        end
        else if (ctrl.div_start && !div_busy_reg)
        begin
            div_busy_reg <= 1'b1;
            dcnt_reg     <= '0;
        end
        else if (ctrl.emit)
            div_busy_reg <= 1'b0;
        else if (div_busy_reg && ctrl.div_step)
            dcnt_reg <= dcnt_reg + 1'b1;
    end

    assign div_last = div_busy_reg && (dcnt_reg == (DC_W + 1)'(DIV_N));

    always_ff @(posedge clk)
    begin
        logic [Q_W:0] trial;
        if (ctrl.div_start && !div_busy_reg)
        begin
            num_reg <= Q_W'(NUM_ROWS) << 32;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (div_busy_reg && ctrl.div_step && !div_last)
        begin
            trial = {rem_reg[Q_W-1:0], num_reg[Q_W-1]};
            num_reg <= num_reg << 1;
            if (trial >= {1'b0, sum_reg})
            begin
                rem_reg <= trial - {1'b0, sum_reg};
                quo_reg <= {quo_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[Q_W-2:0], 1'b0};
            end
        end
    end

    // estimate = h + h/2, saturated; h < 2^41 so 65 bits is ample
    logic [Q_W:0] est_full;
    assign est_full = {1'b0, quo_reg} + {2'b0, quo_reg[Q_W-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else
            result_valid <= ctrl.emit;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
            estimate <= (est_full[Q_W:32] != '0) ? 32'hFFFF_FFFF : est_full[31:0];
    end

endmodule

// ===== hdl/permuted_fm_sketch_core.sv =====
// ----------------------------------------------------------------------------
// permuted_fm_sketch_core
// Cardinality sketch with one bitmap per permutation row.
//
//   channel   | handshake         | payload
//   request   | start / busy      | kind, hash_value, row_index, row_order
//   result    | done (strobe)     | estimate
//
// A load never raises busy. An offer walks every row, one per cycle, then
// drains the read pipeline. A query walks the rows, waits for the last term,
// then runs a 64-step serial divider and emits.
// Reset clears all bitmaps at once through per-row valid flags.
// done is high one cycle; the receiver takes it in that cycle.
// ----------------------------------------------------------------------------
module permuted_fm_sketch_core
#(
    parameter int NUM_ROWS    = pfms_pkg::NUM_ROWS_DEF,
    parameter int NUM_NIBBLES = pfms_pkg::NUM_NIBBLES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] hash_value,
    input  logic [7:0]  row_index,
    input  logic [23:0] row_order,
    output logic        done,
    output logic [31:0] estimate
);

    pfms_pkg::ctrl_t ctrl;
    pfms_pkg::stat_t stat;

    pfms_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    pfms_dp #(
        .NUM_ROWS    (NUM_ROWS),
        .NUM_NIBBLES (NUM_NIBBLES)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .hash_value   (hash_value),
        .row_index    (row_index),
        .row_order    (row_order),
        .stat         (stat),
        .result_valid (done),
        .estimate     (estimate)
    );

endmodule

// ===== hdl/pfms_checker.sv =====
// ----------------------------------------------------------------------------
// pfms_checker
// Port-level checks for the sketch core.
// ----------------------------------------------------------------------------
module pfms_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] kind,
    input logic       done
);

    // an accepted offer or query makes the core busy
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == pfms_pkg::KIND_OFFER || kind == pfms_pkg::KIND_QUERY))
        |=> busy)
        else $error("core not busy after offer or query");

    // a load never makes the core busy
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == pfms_pkg::KIND_LOAD) |=> !busy)
        else $error("load held the core busy");

    // results come only while busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result while idle");

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind permuted_fm_sketch_core pfms_checker u_pfms_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .kind  (kind),
    .done  (done)
);

// ===== test/permuted_fm_sketch_core_test.sv =====
// ----------------------------------------------------------------------------
// permuted_fm_sketch_core_test
// Drives load, offer and query requests into the sketch core with random
// pauses. A local copy of the bitmaps and order table predicts every
// estimate, and each done strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module permuted_fm_sketch_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS      = 256;
    localparam int NIBS      = 8;
    localparam int SUBW      = 32 / NIBS;
    localparam int CYCLE_CAP = 2000000;
    localparam logic [23:0] IDENT_ORDER = 24'hFAC688;   // position j reads sub-word j

    typedef struct {
        pfms_pkg::kind_t kind;
        logic [31:0]     hash;
        logic [7:0]      ridx;
        logic [23:0]     order;
        int              gap;
        bit              drain;
    } request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  kind = pfms_pkg::KIND_NONE;
    logic [31:0] hash_value = '0;
    logic [7:0]  row_index = '0;
    logic [23:0] row_order = '0;
    logic        done;
    logic [31:0] estimate;

    request_t    pending[$];
    logic [31:0] estimates_due[$];
    logic [31:0] sketch_bitmaps[ROWS];
    logic [23:0] sketch_orders[ROWS];

    int          n_requests = 0;
    int          n_accepted = 0;
    int          n_results  = 0;
    int          n_errors   = 0;
    int          cycles     = 0;

    permuted_fm_sketch_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .hash_value (hash_value),
        .row_index  (row_index),
        .row_order  (row_order),
        .done       (done),
        .estimate   (estimate)
    );

    always #5 clk = ~clk;

    // number of significant bits
    function automatic int bit_len(input logic [31:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 32; i++)
            if (v[i])
                n = i + 1;
        return n;
    endfunction

    // update the local sketch for one accepted request
    task automatic apply_request(input request_t rq);
        logic [63:0] total;
        logic [63:0] hmean;
        logic [63:0] est;
        logic [31:0] sub;
        logic [2:0]  k;
        int          offset;
        int          run;
        case (rq.kind)
            pfms_pkg::KIND_LOAD:
                sketch_orders[rq.ridx] = rq.order;
            pfms_pkg::KIND_OFFER:
            begin
                for (int r = 0; r < ROWS; r++)
                begin
                    offset = 0;
                    for (int j = 0; j < NIBS; j++)
                    begin
                        k   = sketch_orders[r][3*j +: 3];
                        sub = (rq.hash >> (k * SUBW)) & ((32'd1 << SUBW) - 1);
                        if (sub == 0)
                            offset += SUBW;
                        else
                        begin
                            offset += SUBW - bit_len(sub);
                            break;
                        end
                    end
                    if (offset <= 31)
                        sketch_bitmaps[r][31 - offset] = 1'b1;
                end
            end
            pfms_pkg::KIND_QUERY:
            begin
                total = '0;
                for (int r = 0; r < ROWS; r++)
                begin
                    run = 32 - bit_len(~sketch_bitmaps[r]);
                    total += 64'd1 << (32 - run);
                end
                hmean = (64'(ROWS) << 32) / total;
                est   = hmean + (hmean >> 1);
                estimates_due = {estimates_due,
                                 (est > 64'hFFFFFFFF) ? 32'hFFFFFFFF : est[31:0]};
            end
            default: ;
        endcase
    endtask

    function automatic request_t mk(input pfms_pkg::kind_t kd, input logic [31:0] h,
                                    input logic [7:0] ri, input logic [23:0] ro);
        request_t rq;
        rq.kind  = kd;
        rq.hash  = h;
        rq.ridx  = ri;
        rq.order = ro;
        rq.gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        rq.drain = 1'b0;
        return rq;
    endfunction

    // request driver
    request_t cur;
    bit       have_cur = 0;
    bit       presenting = 0;
    int       gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_request(cur);
                n_accepted++;
                have_cur   = 0;
                presenting = 0;
            end
            if (!have_cur && pending.size() > 0)
            begin
                cur      = pending.pop_front();
                have_cur = 1;
                gap_left = cur.gap;
            end
            if (have_cur && !presenting)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (!cur.drain || estimates_due.size() == 0)
                    presenting = 1;
            end
            start <= presenting;
            if (have_cur)
            begin
                kind       <= cur.kind;
                hash_value <= cur.hash;
                row_index  <= cur.ridx;
                row_order  <= cur.order;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_results++;
            if (estimates_due.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected estimate %h", estimate);
            end
            else
            begin
                if (estimate !== estimates_due[0])
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: estimate expected %h actual %h",
                                 estimates_due[0], estimate);
                end
                void'(estimates_due.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("ERROR: timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add(input request_t rq);
        pending = {pending, rq};
        n_requests++;
    endtask

    initial
    begin
        request_t rq;
        int       sel;
        int       nib;
        for (int r = 0; r < ROWS; r++)
        begin
            sketch_bitmaps[r] = '0;
            sketch_orders[r]  = '0;
        end

        // directed: empty sketch, table fill, edge hashes, unused kind
        add(mk(pfms_pkg::KIND_QUERY, '0, '0, '0));
        for (int r = 0; r < ROWS; r++)
        begin
            if (r == 0)
                add(mk(pfms_pkg::KIND_LOAD, '0, 8'(r), IDENT_ORDER));
            else if (r == 1)
                add(mk(pfms_pkg::KIND_LOAD, '0, 8'(r), 24'h000000));    // repeated indices
            else if (r == ROWS - 1)
                add(mk(pfms_pkg::KIND_LOAD, '0, 8'(r), 24'hFFFFFF));
            else
                add(mk(pfms_pkg::KIND_LOAD, '0, 8'(r), 24'($urandom)));
        end
        add(mk(pfms_pkg::KIND_OFFER, 32'h00000000, '0, '0));     // sets no bit
        add(mk(pfms_pkg::KIND_QUERY, '0, '0, '0));
        add(mk(pfms_pkg::KIND_OFFER, 32'hFFFFFFFF, '0, '0));
        add(mk(pfms_pkg::KIND_OFFER, 32'h00000001, '0, '0));
        add(mk(pfms_pkg::KIND_OFFER, 32'h80000000, '0, '0));
        add(mk(pfms_pkg::KIND_NONE, 32'hFFFFFFFF, 8'hFF, 24'hFFFFFF));
        add(mk(pfms_pkg::KIND_QUERY, '0, '0, '0));

        // random mix, mostly offers with a spread of leading zeros
        for (int i = 0; i < 450; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
                rq = mk(pfms_pkg::KIND_LOAD, $urandom, 8'($urandom), 24'($urandom));
            else if (sel < 85)
            begin
                if ($urandom_range(0, 40) == 0)
                    rq = mk(pfms_pkg::KIND_OFFER, '0, 8'($urandom), 24'($urandom));
                else
                    rq = mk(pfms_pkg::KIND_OFFER, $urandom >> $urandom_range(0, 31),
                            8'($urandom), 24'($urandom));
            end
            else if (sel < 97)
                rq = mk(pfms_pkg::KIND_QUERY, $urandom, 8'($urandom), 24'($urandom));
            else
                rq = mk(pfms_pkg::KIND_NONE, $urandom, 8'($urandom), 24'($urandom));
            if ($urandom_range(0, 49) == 0)
                rq.drain = 1'b1;
            if (i >= 200 && i < 280)
                rq.gap = 0;                             // back-to-back stretch
            add(rq);
        end

        // closing: identical rows, one hash per offset, full bitmaps saturate
        for (int r = 0; r < ROWS; r++)
            add(mk(pfms_pkg::KIND_LOAD, '0, 8'(r), IDENT_ORDER));
        for (int o = 0; o < 32; o++)
        begin
            nib = o / 4;
            add(mk(pfms_pkg::KIND_OFFER, (32'd1 << (3 - o % 4)) << (4 * nib), '0, '0));
        end
        rq = mk(pfms_pkg::KIND_QUERY, '0, '0, '0);
        rq.drain = 1'b1;
        add(rq);

        repeat (12) @(posedge clk);
        rst_n = 1'b1;

        wait (n_accepted == n_requests && estimates_due.size() == 0);
        repeat (400) @(posedge clk);

        $display("Run covered %0d requests (loads, offers, queries, unused kind)", n_accepted);
        $display("%0d estimates checked, %0d mismatches", n_results, n_errors);
        if (n_errors == 0 && estimates_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
